// ===== rtl/uer_pkg.sv =====
// Package for the ultrasonic echo ranger: codes, constants, register and transaction types.
// No dependencies; used by every module of the block and by its checker.
`default_nettype none

package uer_pkg;

   localparam int unsigned TimerBitsDefault = 16;
   localparam int unsigned CapWidth         = 16;
   localparam int unsigned MinTriggerGapMs  = 50;
   localparam int unsigned DefaultTimeoutMs = 60;
   localparam int unsigned UsPerCm          = 58;
   // floor(y / 29) == (y * Recip29) >> RecipShift for every y below 2**25
   localparam longint unsigned Recip29      = 64'd37025581;
   localparam int unsigned RecipShift       = 30;
   localparam int unsigned RspDepth         = 8;

   localparam logic [2:0] ReqStart    = 3'd0;
   localparam logic [2:0] ReqEdge     = 3'd1;
   localparam logic [2:0] ReqOverflow = 3'd2;
   localparam logic [2:0] ReqRead     = 3'd3;
   localparam logic [2:0] ReqCancel   = 3'd4;

   localparam logic [1:0] StOk      = 2'd0;
   localparam logic [1:0] StError   = 2'd1;
   localparam logic [1:0] StBusy    = 2'd2;
   localparam logic [1:0] StTimeout = 2'd3;

   localparam logic [2:0] CsrEnable      = 3'd0;
   localparam logic [2:0] CsrTimerPeriod = 3'd1;
   localparam logic [2:0] CsrTickUsQ8    = 3'd2;
   localparam logic [2:0] CsrTimeoutMs   = 3'd3;
   localparam logic [2:0] CsrMinDistQ8   = 3'd4;
   localparam logic [2:0] CsrMaxDistQ8   = 3'd5;

   localparam logic [16:0] TimerPeriodReset = 17'd65536;
   localparam logic [15:0] TickUsQ8Reset    = 16'd256;
   localparam logic [19:0] MinDistReset     = 20'd512;
   localparam logic [19:0] MaxDistReset     = 20'd102400;

   typedef enum logic [3:0] {
      PhIdle     = 4'b0001,
      PhRising   = 4'b0010,
      PhFalling  = 4'b0100,
      PhComplete = 4'b1000
   } uer_phase_type;

   typedef struct packed {
      logic        enable;
      logic [16:0] period_ticks;
      logic [15:0] tick_us_q8;
      logic [15:0] wait_limit_ms;
      logic [19:0] min_distance_q8;
      logic [19:0] max_distance_q8;
   } uer_cfg_type;

   typedef struct packed {
      logic        has;
      logic [1:0]  status;
      logic        trigger;
      logic        check;
      logic [31:0] sample_time;
   } uer_tag_type;

   typedef struct packed {
      uer_tag_type tag;
      logic [31:0] ticks;
   } uer_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [19:0] distance_cm_q8;
      logic [31:0] fall_time_ms;
      logic        trigger_pulse;
   } uer_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/uer_ctrl.sv =====
// Measurement sequencer: start, capture edge, overflow, read and cancel handling.
// Depends on uer_pkg; registers one tagged transaction per accepted start or read request.
`default_nettype none

module uer_ctrl #(
   parameter int unsigned TIMER_BITS = uer_pkg::TimerBitsDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [2:0]           req_type,
   input  wire logic [31:0]          req_now_ms,
   input  wire logic [15:0]          req_captured_count,
   input  wire logic                 req_update_pending,
   input  wire uer_pkg::uer_cfg_type cfg,
   output      uer_pkg::uer_item_type item
);
   import uer_pkg::*;

   localparam int unsigned CapBits = (TIMER_BITS < CapWidth) ? TIMER_BITS : CapWidth;

   uer_phase_type phase_ff, phase_in;
   logic [15:0]   rise_count_ff, rise_count_in;
   logic [31:0]   overflow_count_ff, overflow_count_in;
   logic          skip_overflow_ff, skip_overflow_in;
   logic [31:0]   echo_ticks_ff, echo_ticks_in;
   logic [31:0]   finish_time_ff, finish_time_in;
   logic          triggered_once_ff, triggered_once_in;
   logic [31:0]   trigger_time_ff, trigger_time_in;
   uer_item_type  item_ff, item_in;

   logic [15:0] cap;
   logic [15:0] half;
   logic        late;
   logic [31:0] since_trig;
   logic [15:0] limit;
   logic [31:0] ov;
   logic [31:0] span;
   logic [31:0] ticks_calc;

   always_comb begin
      cap = '0;
      cap[CapBits-1:0] = req_captured_count[CapBits-1:0];
      half       = cfg.period_ticks[16:1];
      late       = req_update_pending & (cap < half);
      since_trig = req_now_ms - trigger_time_ff;
      limit      = (cfg.wait_limit_ms != '0) ? cfg.wait_limit_ms : 16'(DefaultTimeoutMs);
      ov         = overflow_count_ff + {31'b0, late};
      span       = ov * {15'b0, cfg.period_ticks};
      if (ov == '0 && cap < rise_count_ff) begin
         ticks_calc = '0;
      end else begin
         ticks_calc = span + {16'b0, cap} - {16'b0, rise_count_ff};
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      rise_count_in     = rise_count_ff;
      overflow_count_in = overflow_count_ff;
      skip_overflow_in  = skip_overflow_ff;
      echo_ticks_in     = echo_ticks_ff;
      finish_time_in    = finish_time_ff;
      triggered_once_in = triggered_once_ff;
      trigger_time_in   = trigger_time_ff;
      item_in           = '0;
      item_in.ticks     = echo_ticks_ff;
      if (accept) begin
         unique case (req_type)
            ReqStart: begin
               item_in.tag.has = 1'b1;
               if (!cfg.enable) begin
                  item_in.tag.status = StError;
               end else if (phase_ff != PhIdle) begin
                  item_in.tag.status = StBusy;
               end else if (triggered_once_ff && since_trig < 32'(MinTriggerGapMs)) begin
                  item_in.tag.status = StBusy;
               end else begin
                  item_in.tag.status  = StOk;
                  item_in.tag.trigger = 1'b1;
                  phase_in            = PhRising;
                  rise_count_in       = '0;
                  overflow_count_in   = '0;
                  echo_ticks_in       = '0;
                  skip_overflow_in    = 1'b0;
                  finish_time_in      = '0;
                  trigger_time_in     = req_now_ms;
                  triggered_once_in   = 1'b1;
               end
            end
            ReqEdge: begin
               if (cfg.enable && phase_ff == PhRising) begin
                  rise_count_in     = cap;
                  overflow_count_in = '0;
                  if (late) begin
                     skip_overflow_in = 1'b1;
                  end
                  phase_in = PhFalling;
               end else if (cfg.enable && phase_ff == PhFalling) begin
                  echo_ticks_in  = ticks_calc;
                  finish_time_in = req_now_ms;
                  phase_in       = PhComplete;
               end
            end
            ReqOverflow: begin
               if (cfg.enable && phase_ff == PhFalling) begin
                  if (skip_overflow_ff) begin
                     skip_overflow_in = 1'b0;
                  end else begin
                     overflow_count_in = overflow_count_ff + 32'd1;
                  end
               end
            end
            ReqRead: begin
               item_in.tag.has = 1'b1;
               if (!cfg.enable || phase_ff == PhIdle) begin
                  item_in.tag.status = StError;
               end else if (phase_ff != PhComplete) begin
                  if (since_trig >= {16'b0, limit}) begin
                     item_in.tag.status = StTimeout;
                     phase_in           = PhIdle;
                  end else begin
                     item_in.tag.status = StBusy;
                  end
               end else begin
                  phase_in = PhIdle;
                  if (echo_ticks_ff == '0) begin
                     item_in.tag.status = StError;
                  end else begin
                     item_in.tag.status      = StOk;
                     item_in.tag.check       = 1'b1;
                     item_in.tag.sample_time = finish_time_ff;
                  end
               end
            end
            ReqCancel: begin
               if (cfg.enable) begin
                  phase_in = PhIdle;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PhIdle;
         rise_count_ff     <= '0;
         overflow_count_ff <= '0;
         skip_overflow_ff  <= 1'b0;
         echo_ticks_ff     <= '0;
         finish_time_ff    <= '0;
         triggered_once_ff <= 1'b0;
         trigger_time_ff   <= '0;
         item_ff.tag.has   <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         rise_count_ff     <= rise_count_in;
         overflow_count_ff <= overflow_count_in;
         skip_overflow_ff  <= skip_overflow_in;
         echo_ticks_ff     <= echo_ticks_in;
         finish_time_ff    <= finish_time_in;
         triggered_once_ff <= triggered_once_in;
         trigger_time_ff   <= trigger_time_in;
         item_ff.tag.has   <= item_in.tag.has;
      end
      item_ff.tag.status      <= item_in.tag.status;
      item_ff.tag.trigger     <= item_in.tag.trigger;
      item_ff.tag.check       <= item_in.tag.check;
      item_ff.tag.sample_time <= item_in.tag.sample_time;
      item_ff.ticks           <= item_in.ticks;
   end

   assign item = item_ff;

endmodule

`default_nettype wire

// ===== rtl/uer_range.sv =====
// Distance stages: echo time product, divide by 58 through a reciprocal, limit check.
// Depends on uer_pkg; takes the sequencer's transaction, yields one result per cycle.
`default_nettype none

module uer_range (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire uer_pkg::uer_item_type item,
   input  wire uer_pkg::uer_cfg_type  cfg,
   output      logic                  push,
   output      uer_pkg::uer_rsp_type  rsp
);
   import uer_pkg::*;

   uer_tag_type s2_tag_ff;
   logic [47:0] prod_ff;
   uer_tag_type s3_tag_ff;
   logic [19:0] quot_ff;
   logic        bad_ff;

   logic [25:0] lo_bound;
   logic [25:0] hi_bound;
   logic [24:0] half_prod;
   logic [50:0] recip_prod;
   logic        bad;

   always_comb begin
      lo_bound   = {6'b0, cfg.min_distance_q8} * 26'(UsPerCm);
      hi_bound   = {6'b0, cfg.max_distance_q8} * 26'(UsPerCm) + 26'(UsPerCm - 1);
      half_prod  = prod_ff[25:1];
      recip_prod = {26'b0, half_prod} * 51'(Recip29);
      bad        = (prod_ff < {22'b0, lo_bound}) || (prod_ff > {22'b0, hi_bound});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_tag_ff.has <= 1'b0;
         s3_tag_ff.has <= 1'b0;
      end else begin
         s2_tag_ff.has <= item.tag.has;
         s3_tag_ff.has <= s2_tag_ff.has;
      end
      s2_tag_ff.status      <= item.tag.status;
      s2_tag_ff.trigger     <= item.tag.trigger;
      s2_tag_ff.check       <= item.tag.check;
      s2_tag_ff.sample_time <= item.tag.sample_time;
      prod_ff               <= {16'b0, item.ticks} * {32'b0, cfg.tick_us_q8};
      s3_tag_ff.status      <= s2_tag_ff.status;
      s3_tag_ff.trigger     <= s2_tag_ff.trigger;
      s3_tag_ff.check       <= s2_tag_ff.check;
      s3_tag_ff.sample_time <= s2_tag_ff.sample_time;
      quot_ff               <= recip_prod[RecipShift +: 20];
      bad_ff                <= bad;
   end

   always_comb begin
      push              = s3_tag_ff.has;
      rsp.status        = s3_tag_ff.status;
      rsp.trigger_pulse = s3_tag_ff.trigger;
      rsp.distance_cm_q8 = '0;
      rsp.fall_time_ms   = '0;
      if (s3_tag_ff.check) begin
         if (bad_ff) begin
            rsp.status = StError;
         end else begin
            rsp.distance_cm_q8 = quot_ff;
            rsp.fall_time_ms   = s3_tag_ff.sample_time;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ultrasonic_echo_ranger.sv =====
// Top level of the ultrasonic echo ranger: registers, sequencer, distance stages, result queue.
// Depends on uer_pkg, uer_ctrl and uer_range.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_stall | req_type, req_now_ms, req_captured_count,
//           |           |                     | req_update_pending
//   rsp_    | out       | rsp_valid/rsp_stall | rsp_status, rsp_distance_cm_q8,
//           |           |                     | rsp_fall_time_ms, rsp_trigger_pulse
//   csr_    | in        | csr_valid/csr_ready | csr_index, csr_data (ready always high)
//
// One request per clock while req_stall is low. A start or read gives its result through
// the sequencer register, the multiply stage and the divide/limit stage.
// Results wait in an 8-entry queue; req_stall rises while 8 results are outstanding.
// Synchronous reset clears the queue and the measurement state.
`default_nettype none

module ultrasonic_echo_ranger #(
   parameter int unsigned TIMER_BITS = uer_pkg::TimerBitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [2:0]  req_type,
   input  wire logic [31:0] req_now_ms,
   input  wire logic [15:0] req_captured_count,
   input  wire logic        req_update_pending,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_status,
   output      logic [19:0] rsp_distance_cm_q8,
   output      logic [31:0] rsp_fall_time_ms,
   output      logic        rsp_trigger_pulse,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [19:0] csr_data
);
   import uer_pkg::*;

   localparam int unsigned PtrBits = $clog2(RspDepth);
   localparam int unsigned OccBits = $clog2(RspDepth + 1);

   uer_cfg_type  cfg_ff, cfg_in;
   uer_item_type item;
   uer_rsp_type  push_rsp;
   logic         push;

   uer_rsp_type        queue_ff [RspDepth];
   logic [PtrBits-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [OccBits-1:0] count_ff, count_in;
   logic [OccBits-1:0] occ_ff, occ_in;

   logic accept;
   logic pop;
   logic res_accept;

   assign csr_ready  = 1'b1;
   assign accept     = req_valid & ~req_stall;
   assign pop        = rsp_valid & ~rsp_stall;
   assign res_accept = accept & ((req_type == ReqStart) | (req_type == ReqRead));
   assign req_stall  = (occ_ff == OccBits'(RspDepth));
   assign rsp_valid  = (count_ff != '0);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrEnable:      cfg_in.enable          = csr_data[0];
            CsrTimerPeriod: cfg_in.period_ticks    = csr_data[16:0];
            CsrTickUsQ8:    cfg_in.tick_us_q8      = csr_data[15:0];
            CsrTimeoutMs:   cfg_in.wait_limit_ms   = csr_data[15:0];
            CsrMinDistQ8:   cfg_in.min_distance_q8 = csr_data;
            CsrMaxDistQ8:   cfg_in.max_distance_q8 = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      occ_in   = occ_ff + OccBits'(res_accept) - OccBits'(pop);
      count_in = count_ff + OccBits'(push) - OccBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable          <= 1'b0;
         cfg_ff.period_ticks    <= TimerPeriodReset;
         cfg_ff.tick_us_q8      <= TickUsQ8Reset;
         cfg_ff.wait_limit_ms   <= '0;
         cfg_ff.min_distance_q8 <= MinDistReset;
         cfg_ff.max_distance_q8 <= MaxDistReset;
         wr_ptr_ff              <= '0;
         rd_ptr_ff              <= '0;
         count_ff               <= '0;
         occ_ff                 <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         count_ff <= count_in;
         occ_ff   <= occ_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PtrBits'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PtrBits'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_rsp;
      end
   end

   assign rsp_status         = queue_ff[rd_ptr_ff].status;
   assign rsp_distance_cm_q8 = queue_ff[rd_ptr_ff].distance_cm_q8;
   assign rsp_fall_time_ms   = queue_ff[rd_ptr_ff].fall_time_ms;
   assign rsp_trigger_pulse  = queue_ff[rd_ptr_ff].trigger_pulse;

   uer_ctrl #(
      .TIMER_BITS (TIMER_BITS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .req_type           (req_type),
      .req_now_ms         (req_now_ms),
      .req_captured_count (req_captured_count),
      .req_update_pending (req_update_pending),
      .cfg                (cfg_ff),
      .item               (item)
   );

   uer_range u_range (
      .clock (clock),
      .reset (reset),
      .item  (item),
      .cfg   (cfg_ff),
      .push  (push),
      .rsp   (push_rsp)
   );

endmodule

`default_nettype wire

// ===== rtl/uer_checker.sv =====
// Port-level checker for the ultrasonic echo ranger, bound to the top level.
// Depends on uer_pkg for the status codes.
`default_nettype none

module uer_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic [19:0] rsp_distance_cm_q8,
   input wire logic [31:0] rsp_fall_time_ms,
   input wire logic        rsp_trigger_pulse
);
   import uer_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_distance_cm_q8) && $stable(rsp_fall_time_ms)
         && $stable(rsp_trigger_pulse))
      else $error("result changed while stalled");

   a_trigger_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trigger_pulse |-> rsp_status == StOk && rsp_distance_cm_q8 == '0
         && rsp_fall_time_ms == '0)
      else $error("trigger pulse on a result that is not a clean start");

   a_no_data_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != StOk |-> rsp_distance_cm_q8 == '0
         && rsp_fall_time_ms == '0 && !rsp_trigger_pulse)
      else $error("measurement data on a failed transaction");

   a_ready_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_stall && !rsp_valid)
      else $error("queue not empty after reset");

endmodule

bind ultrasonic_echo_ranger uer_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_distance_cm_q8 (rsp_distance_cm_q8),
   .rsp_fall_time_ms   (rsp_fall_time_ms),
   .rsp_trigger_pulse  (rsp_trigger_pulse)
);

`default_nettype wire

// ===== test/ultrasonic_echo_ranger_tb.sv =====
`timescale 1ns / 1ps
// Testbench for ultrasonic_echo_ranger: directed table, then random ranging sequences over
// several register settings; results checked against the table entry or a local predictor.
// Depends on uer_pkg and the ultrasonic_echo_ranger RTL.
module ultrasonic_echo_ranger_tb;
   import uer_pkg::*;

   localparam int unsigned IdleLimit    = 4000;
   localparam int unsigned DrainCycles  = 8;
   localparam int unsigned DisabledRows = 3;

   typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_type;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] now;
      logic [15:0] cap;
      logic        pend;
      bit          typed;
      uer_rsp_type rsp;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_type = '0;
   logic [31:0] req_now_ms = '0;
   logic [15:0] req_captured_count = '0;
   logic        req_update_pending = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [19:0] rsp_distance_cm_q8;
   logic [31:0] rsp_fall_time_ms;
   logic        rsp_trigger_pulse;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [19:0] csr_data = '0;

   idle_mode_type idle_mode = IdleNone;
   uer_rsp_type   expected_results[$];
   stim_row_type  stim_table[$];
   int unsigned   mismatch_count = 0;
   int unsigned   quiet_cycles = 0;
   int unsigned   items_sent = 0;

   // ranging state mirror
   uer_cfg_type   cfg;
   uer_phase_type ph;
   logic [15:0]   rise_cnt;
   logic [31:0]   ovf_cnt;
   logic          skip_ovf;
   logic [31:0]   echo_len;
   logic [31:0]   fall_ms;
   logic          armed_once;
   logic [31:0]   trig_ms;

   ultrasonic_echo_ranger uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_now_ms         (req_now_ms),
      .req_captured_count (req_captured_count),
      .req_update_pending (req_update_pending),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_distance_cm_q8 (rsp_distance_cm_q8),
      .rsp_fall_time_ms   (rsp_fall_time_ms),
      .rsp_trigger_pulse  (rsp_trigger_pulse),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void reset_ranging_state();
      cfg.enable          = 1'b0;
      cfg.period_ticks    = TimerPeriodReset;
      cfg.tick_us_q8      = TickUsQ8Reset;
      cfg.wait_limit_ms   = '0;
      cfg.min_distance_q8 = MinDistReset;
      cfg.max_distance_q8 = MaxDistReset;
      ph         = PhIdle;
      rise_cnt   = '0;
      ovf_cnt    = '0;
      skip_ovf   = 1'b0;
      echo_len   = '0;
      fall_ms    = '0;
      armed_once = 1'b0;
      trig_ms    = '0;
   endfunction

   function automatic bit predict_echo_result(input logic [2:0] kind, input logic [31:0] now,
                                              input logic [15:0] cap, input logic pend,
                                              output uer_rsp_type r);
      logic [16:0] half;
      logic        late;
      logic [31:0] ov;
      logic [31:0] lim;
      logic [47:0] echo_q8;
      bit          has;
      r    = '0;
      has  = 1'b0;
      half = cfg.period_ticks >> 1;
      late = pend && ({1'b0, cap} < half);
      lim  = (cfg.wait_limit_ms != 0) ? {16'b0, cfg.wait_limit_ms} : DefaultTimeoutMs;
      case (kind)
         ReqStart: begin
            has = 1'b1;
            if (!cfg.enable) begin
               r.status = StError;
            end else if (ph != PhIdle || (armed_once && (now - trig_ms) < MinTriggerGapMs)) begin
               r.status = StBusy;
            end else begin
               ph         = PhRising;
               rise_cnt   = '0;
               ovf_cnt    = '0;
               echo_len   = '0;
               skip_ovf   = 1'b0;
               fall_ms    = '0;
               trig_ms    = now;
               armed_once = 1'b1;
               r.status   = StOk;
               r.trigger_pulse = 1'b1;
            end
         end
         ReqEdge: begin
            if (cfg.enable && ph == PhRising) begin
               rise_cnt = cap;
               ovf_cnt  = '0;
               if (late) skip_ovf = 1'b1;
               ph = PhFalling;
            end else if (cfg.enable && ph == PhFalling) begin
               ov = ovf_cnt + {31'b0, late};
               if (ov == 0 && cap < rise_cnt) echo_len = '0;
               else echo_len = ov * cfg.period_ticks + cap - rise_cnt;
               fall_ms = now;
               ph      = PhComplete;
            end
         end
         ReqOverflow: begin
            if (cfg.enable && ph == PhFalling) begin
               if (skip_ovf) skip_ovf = 1'b0;
               else ovf_cnt = ovf_cnt + 1;
            end
         end
         ReqRead: begin
            has = 1'b1;
            if (!cfg.enable || ph == PhIdle) begin
               r.status = StError;
            end else if (ph != PhComplete) begin
               if ((now - trig_ms) >= lim) begin
                  ph       = PhIdle;
                  r.status = StTimeout;
               end else begin
                  r.status = StBusy;
               end
            end else begin
               ph = PhIdle;
               echo_q8 = {16'b0, echo_len} * {32'b0, cfg.tick_us_q8} / UsPerCm;
               if (echo_len == 0 || echo_q8 < {28'b0, cfg.min_distance_q8}
                   || echo_q8 > {28'b0, cfg.max_distance_q8}) begin
                  r.status = StError;
               end else begin
                  r.status         = StOk;
                  r.distance_cm_q8 = echo_q8[19:0];
                  r.fall_time_ms   = fall_ms;
               end
            end
         end
         ReqCancel: begin
            if (cfg.enable) ph = PhIdle;
         end
         default: begin
         end
      endcase
      return has;
   endfunction

   function automatic void flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", what);
   endfunction

   function automatic void add_row(input logic [2:0] kind, input logic [31:0] now,
                                   input logic [15:0] cap, input logic pend, input bit typed,
                                   input logic [1:0] status, input logic trig);
      stim_row_type row;
      row.kind  = kind;
      row.now   = now;
      row.cap   = cap;
      row.pend  = pend;
      row.typed = typed;
      row.rsp   = '0;
      row.rsp.status = status;
      row.rsp.trigger_pulse = trig;
      stim_table.push_back(row);
   endfunction

   task automatic send_item(input logic [2:0] kind, input logic [31:0] now,
                            input logic [15:0] cap, input logic pend, input bit typed,
                            input uer_rsp_type typed_rsp);
      uer_rsp_type r;
      bit          has;
      int unsigned pct;
      pct = (idle_mode == IdleSender) ? 81 : (idle_mode == IdleBoth) ? 20 : 0;
      while ($urandom_range(99) < pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_now_ms         <= now;
      req_captured_count <= cap;
      req_update_pending <= pend;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      has = predict_echo_result(kind, now, cap, pend, r);
      if (has) expected_results.push_back(typed ? typed_rsp : r);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_config(input uer_cfg_type c);
      logic [2:0]  idx[6];
      logic [19:0] vals[6];
      idx  = '{CsrEnable, CsrTimerPeriod, CsrTickUsQ8, CsrTimeoutMs, CsrMinDistQ8, CsrMaxDistQ8};
      vals = '{{19'b0, c.enable}, {3'b0, c.period_ticks}, {4'b0, c.tick_us_q8},
               {4'b0, c.wait_limit_ms}, c.min_distance_q8, c.max_distance_q8};
      settle();
      for (int k = 0; k < 6; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= vals[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
      cfg = c;
   endtask

   task automatic run_phase(input idle_mode_type mode, input int unsigned n,
                            input logic [31:0] base);
      logic [31:0] t;
      logic [15:0] rise;
      logic [15:0] fall;
      int unsigned first;
      int unsigned k;
      bit          paused;
      idle_mode = mode;
      t      = base;
      first  = items_sent;
      paused = 1'b0;
      while (items_sent - first < n) begin
         if (!paused && items_sent - first >= n / 2) begin
            // hold the sender until the block has nothing outstanding
            req_valid <= 1'b0;
            do @(posedge clock); while (expected_results.size() != 0);
            paused = 1'b1;
         end
         if ($urandom_range(99) < 12) begin
            send_item(3'($urandom_range(7)),
                      ($urandom_range(3) == 0) ? $urandom() : t + $urandom_range(200),
                      16'($urandom_range(65535)), 1'($urandom_range(1)), 1'b0, '0);
         end else begin
            t = t + (($urandom_range(3) == 0) ? $urandom_range(60) : $urandom_range(150, 50));
            send_item(ReqStart, t, 16'($urandom_range(65535)), 1'($urandom_range(1)),
                      1'b0, '0);
            if ($urandom_range(9) == 0)
               send_item(ReqRead, t + $urandom_range(120), 16'($urandom_range(65535)),
                         1'($urandom_range(1)), 1'b0, '0);
            rise = 16'($urandom_range(65535));
            send_item(ReqEdge, t + $urandom_range(3), rise, 1'($urandom_range(1)), 1'b0, '0);
            for (k = $urandom_range(3); k > 0; k--)
               send_item(ReqOverflow, t + $urandom_range(30), 16'($urandom_range(65535)),
                         1'($urandom_range(1)), 1'b0, '0);
            if ($urandom_range(19) == 0)
               send_item(ReqCancel, t + $urandom_range(30), 16'($urandom_range(65535)),
                         1'($urandom_range(1)), 1'b0, '0);
            fall = $urandom_range(1) ? rise + 16'($urandom_range(30000))
                                     : 16'($urandom_range(65535));
            send_item(ReqEdge, t + $urandom_range(30, 1), fall, 1'($urandom_range(1)),
                      1'b0, '0);
            if ($urandom_range(9) != 0)
               send_item(ReqRead, t + $urandom_range(80, 1), 16'($urandom_range(65535)),
                         1'($urandom_range(1)), 1'b0, '0);
         end
      end
   endtask

   always @(posedge clock) begin : rsp_check
      uer_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               flag_mismatch("result with nothing expected");
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch($sformatf("status expected %0d, got %0d",
                                          want.status, rsp_status));
               if (rsp_distance_cm_q8 !== want.distance_cm_q8)
                  flag_mismatch($sformatf("distance expected %0d, got %0d",
                                          want.distance_cm_q8, rsp_distance_cm_q8));
               if (rsp_fall_time_ms !== want.fall_time_ms)
                  flag_mismatch($sformatf("sample time expected %0d, got %0d",
                                          want.fall_time_ms, rsp_fall_time_ms));
               if (rsp_trigger_pulse !== want.trigger_pulse)
                  flag_mismatch($sformatf("trigger expected %0d, got %0d",
                                          want.trigger_pulse, rsp_trigger_pulse));
            end
         end
         case (idle_mode)
            IdleReceiver: rsp_stall <= ($urandom_range(99) < 81);
            IdleBoth:     rsp_stall <= ($urandom_range(99) < 20);
            default:      rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : main
      uer_cfg_type c;
      reset_ranging_state();

      // disabled block
      add_row(ReqStart,    32'd5,          16'd0,     1'b0, 1'b1, StError,   1'b0);
      add_row(ReqRead,     32'd6,          16'd0,     1'b0, 1'b1, StError,   1'b0);
      add_row(ReqCancel,   32'd7,          16'd0,     1'b0, 1'b0, StOk,      1'b0);
      // enabled, reset settings
      add_row(ReqRead,     32'd1000,       16'd0,     1'b0, 1'b1, StError,   1'b0);
      add_row(ReqStart,    32'd1000,       16'd0,     1'b0, 1'b1, StOk,      1'b1);
      add_row(ReqStart,    32'd1001,       16'd0,     1'b0, 1'b1, StBusy,    1'b0);
      add_row(ReqRead,     32'd1010,       16'd0,     1'b0, 1'b1, StBusy,    1'b0);
      add_row(ReqRead,     32'd1060,       16'd0,     1'b0, 1'b1, StTimeout, 1'b0);
      add_row(ReqStart,    32'd1040,       16'd0,     1'b0, 1'b1, StBusy,    1'b0);
      add_row(ReqStart,    32'd1050,       16'd0,     1'b0, 1'b1, StOk,      1'b1);
      add_row(ReqEdge,     32'd1051,       16'd1000,  1'b0, 1'b0, StOk,      1'b0);
      add_row(ReqEdge,     32'd1053,       16'd6800,  1'b0, 1'b0, StOk,      1'b0);
      add_row(ReqRead,     32'd1054,       16'd0,     1'b0, 1'b0, StOk,      1'b0);
      add_row(ReqStart,    32'd1110,       16'd0,     1'b0, 1'b1, StOk,      1'b1);
      add_row(ReqEdge,     32'd1111,       16'd500,   1'b0, 1'b0, StOk,      1'b0);
      add_row(ReqEdge,     32'd1112,       16'd400,   1'b0, 1'b0, StOk,      1'b0);
      add_row(ReqRead,     32'd1113,       16'd0,     1'b0, 1'b1, StError,   1'b0);
      add_row(ReqStart,    32'd1200,       16'd0,     1'b0, 1'b1, StOk,      1'b1);
      add_row(ReqEdge,     32'd1201,       16'd10,    1'b1, 1'b0, StOk,      1'b0);
      add_row(ReqOverflow, 32'd1202,       16'd0,     1'b0, 1'b0, StOk,      1'b0);
      add_row(ReqOverflow, 32'd1203,       16'd0,     1'b0, 1'b0, StOk,      1'b0);
      add_row(ReqEdge,     32'd1204,       16'hFFFF,  1'b1, 1'b0, StOk,      1'b0);
      add_row(ReqRead,     32'd1205,       16'd0,     1'b0, 1'b0, StOk,      1'b0);
      add_row(ReqStart,    32'd1400,       16'd0,     1'b0, 1'b1, StOk,      1'b1);
      add_row(ReqCancel,   32'd1401,       16'd0,     1'b0, 1'b0, StOk,      1'b0);
      add_row(ReqRead,     32'd1402,       16'd0,     1'b0, 1'b1, StError,   1'b0);
      add_row(3'd7,        32'd1403,       16'hFFFF,  1'b1, 1'b0, StOk,      1'b0);
      add_row(ReqStart,    32'hFFFF_FFF0,  16'd0,     1'b0, 1'b1, StOk,      1'b1);
      add_row(ReqRead,     32'h0000_002B,  16'd0,     1'b0, 1'b1, StBusy,    1'b0);
      add_row(ReqRead,     32'h0000_002C,  16'd0,     1'b0, 1'b1, StTimeout, 1'b0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < stim_table.size(); i++) begin
         if (i == DisabledRows) begin
            c = cfg;
            c.enable = 1'b1;
            set_config(c);
         end
         send_item(stim_table[i].kind, stim_table[i].now, stim_table[i].cap,
                   stim_table[i].pend, stim_table[i].typed, stim_table[i].rsp);
      end

      run_phase(IdleNone, 400, $urandom());

      c.enable          = 1'b1;
      c.period_ticks    = 17'd1;
      c.tick_us_q8      = 16'd1;
      c.wait_limit_ms   = 16'hFFFF;
      c.min_distance_q8 = 20'd0;
      c.max_distance_q8 = 20'hFFFFF;
      set_config(c);
      run_phase(IdleSender, 400, 32'hFFFF_F000 + $urandom_range(2000));

      c.period_ticks    = 17'd65536;
      c.tick_us_q8      = 16'hFFFF;
      c.wait_limit_ms   = 16'd1;
      set_config(c);
      run_phase(IdleReceiver, 400, $urandom());

      c.period_ticks    = 17'($urandom_range(65536, 1));
      c.tick_us_q8      = 16'($urandom_range(65535, 1));
      c.wait_limit_ms   = 16'($urandom_range(200));
      c.min_distance_q8 = 20'($urandom_range(5000));
      c.max_distance_q8 = 20'($urandom_range(20'hFFFFF, 20000));
      set_config(c);
      run_phase(IdleBoth, 400, $urandom());

      c.enable = 1'b0;
      set_config(c);
      run_phase(IdleNone, 100, $urandom());

      c.enable          = 1'b1;
      c.period_ticks    = 17'($urandom_range(4096, 1));
      c.tick_us_q8      = 16'($urandom_range(65535, 1));
      c.wait_limit_ms   = 16'd0;
      c.min_distance_q8 = 20'($urandom_range(1000));
      c.max_distance_q8 = 20'($urandom_range(20'hFFFFF, 50000));
      set_config(c);
      run_phase(IdleSender, 300, $urandom());

      c.min_distance_q8 = 20'hFFFFF;
      c.max_distance_q8 = 20'd0;
      set_config(c);
      run_phase(IdleReceiver, 100, $urandom());

      settle();
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
